// ===== rtl/core/rms_pkg.sv =====
// shared types and constants for the running mean / stddev / sem block
// no dependencies; imported by rms_unit, running_mean_stddev_sem and tb
`timescale 1ns / 1ps

package rms_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_MAX   = 65535;
    localparam int FRAC_BITS   = 8;

    localparam int CNT_W  = 16;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int SUM_W  = CNT_W + DIFF_W + 1;
    localparam int SQ_W   = CNT_W + 2 * DIFF_W;
    localparam int OUT_W  = 25;

    // wide datapath of the shared unit: (n*s2 - s*s) shifted by two fraction widths
    localparam int UW = CNT_W + SQ_W + 2 * FRAC_BITS;
    localparam int MB = SUM_W;
    localparam int RW = UW / 2 + 4;
    localparam int CW = $clog2(UW + 1);

    localparam logic [OUT_W-1:0] MEAN_SAT = OUT_W'((1 << (OUT_W - 1)) - 1);
    localparam logic [OUT_W-1:0] ROOT_SAT = OUT_W'((1 << OUT_W) - 1);

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FEW     = 2'd1,
        STAT_NEGVAR  = 2'd2,
        STAT_IGNORED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } t_op;

    typedef struct packed {
        logic            start;
        t_op             op;
        logic [UW-1:0]   a;
        logic [MB-1:0]   b;
    } t_ucmd;

    typedef struct packed {
        logic            done;
        logic            busy;
        logic [UW-1:0]   value;
    } t_ures;

endpackage

// ===== rtl/core/rms_unit.sv =====
// shared bit-serial unit: shift-add multiply, restoring divide, digit square root
// depends on rms_pkg
`timescale 1ns / 1ps

module rms_unit import rms_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ucmd i_cmd,
    output t_ures o_res
);

    localparam logic [CW-1:0] LAST_MUL  = CW'(MB - 1);
    localparam logic [CW-1:0] LAST_DIV  = CW'(UW - 1);
    localparam logic [CW-1:0] LAST_SQRT = CW'(UW / 2 - 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    t_op           r_op, n_op;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [UW-1:0] r_x, n_x;
    logic [UW-1:0] r_acc, n_acc;
    logic [MB-1:0] r_b, n_b;
    logic [RW-1:0] r_rem, n_rem;

    logic [RW-1:0] w_dtry;
    logic [RW-1:0] w_stry;
    logic [RW-1:0] w_sroot;
    logic [CW-1:0] w_last;

    always_comb begin
        w_dtry  = {r_rem[RW-2:0], r_x[UW-1]};
        w_stry  = {r_rem[RW-3:0], r_x[UW-1:UW-2]};
        w_sroot = {r_acc[RW-3:0], 2'b01};
        unique case (r_op)
            OP_MUL:  w_last = LAST_MUL;
            OP_DIV:  w_last = LAST_DIV;
            default: w_last = LAST_SQRT;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_acc  = r_acc;
        n_b    = r_b;
        n_rem  = r_rem;
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_op   = i_cmd.op;
            n_cnt  = '0;
            n_x    = i_cmd.a;
            n_b    = i_cmd.b;
            n_acc  = '0;
            n_rem  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + CW'(1);
            unique case (r_op)
                OP_MUL: begin
                    if (r_b[0]) n_acc = r_acc + r_x;
                    n_x = {r_x[UW-2:0], 1'b0};
                    n_b = {1'b0, r_b[MB-1:1]};
                end
                OP_DIV: begin
                    n_x = {r_x[UW-2:0], 1'b0};
                    if (w_dtry >= RW'(r_b)) begin
                        n_rem = w_dtry - RW'(r_b);
                        n_acc = {r_acc[UW-2:0], 1'b1};
                    end else begin
                        n_rem = w_dtry;
                        n_acc = {r_acc[UW-2:0], 1'b0};
                    end
                end
                default: begin
                    n_x = {r_x[UW-3:0], 2'b00};
                    if (w_stry >= w_sroot) begin
                        n_rem = w_stry - w_sroot;
                        n_acc = {r_acc[UW-2:0], 1'b1};
                    end else begin
                        n_rem = w_stry;
                        n_acc = {r_acc[UW-2:0], 1'b0};
                    end
                end
            endcase
            if (r_cnt == w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_x   <= n_x;
        r_acc <= n_acc;
        r_b   <= n_b;
        r_rem <= n_rem;
    end

    assign o_res.done  = r_done;
    assign o_res.busy  = r_busy;
    assign o_res.value = r_acc;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_cmd.start)
        else $error("unit started while busy");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("unit done while still busy");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= LAST_DIV)
        else $error("unit step count out of range");

endmodule

// ===== rtl/core/running_mean_stddev_sem.sv =====
// Running mean, sample standard deviation and standard error with exact integer
// accumulators. Each accepted item updates count, sum and sum
// of squares; the statistics are then worked out on one shared bit-serial unit
// (shift-add multiply, restoring divide, digit square root), one bit per cycle.
// No unit step runs when no samples are held. Only the 82-step mean divide runs
// when fewer than two samples are held, the request is ignored or the sum of
// squares is negative. The full statistics take two 34-step multiplies, three
// 82-step divides and two 41-step roots, each with a launch and a done cycle; a
// negative variance found after the two multiplies ends the work there. While
// the output stalls, the block waits in its output state. o_in_stall is high
// while an item is in work. A new item can be taken while the previous result
// still waits at the output.
// depends on rms_pkg and rms_unit
`timescale 1ns / 1ps

module running_mean_stddev_sem import rms_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_req_type,
    input  logic signed [15:0]     i_sample,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_status,
    output logic [15:0]            o_count,
    output logic signed [32:0]     o_total,
    output logic signed [48:0]     o_total_squares,
    output logic signed [24:0]     o_mean_q8,
    output logic [24:0]            o_stddev_q8,
    output logic [24:0]            o_sem_q8,
    output logic signed [16:0]     o_last_value
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_UPD  = 10'b0000000010,
        S_MEAN = 10'b0000000100,
        S_NS2  = 10'b0000001000,
        S_SS   = 10'b0000010000,
        S_QDIV = 10'b0000100000,
        S_SD   = 10'b0001000000,
        S_QN   = 10'b0010000000,
        S_SE   = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_launch, n_launch;

    logic [SAMPLE_BITS-1:0] r_base;
    logic [1:0]             r_req;
    logic [DIFF_W-1:0]      r_d;
    logic                   r_ign, n_ign;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [SQ_W-1:0]        r_sq, n_sq;
    logic [DIFF_W-1:0]      r_last, n_last;
    t_status                r_status, n_status;
    logic [OUT_W-1:0]       r_mean, n_mean;
    logic [OUT_W-1:0]       r_sd, n_sd;
    logic [OUT_W-1:0]       r_se, n_se;
    logic [UW-1:0]          r_na, n_na;
    logic [UW-1:0]          r_q, n_q;

    logic                   r_ov, n_ov;
    t_status                r_o_status;
    logic [CNT_W-1:0]       r_o_count;
    logic [32:0]            r_o_total;
    logic [48:0]            r_o_sq;
    logic [OUT_W-1:0]       r_o_mean;
    logic [OUT_W-1:0]       r_o_sd;
    logic [OUT_W-1:0]       r_o_se;
    logic [DIFF_W-1:0]      r_o_last;

    t_ucmd                  w_cmd;
    t_ures                  w_res;
    logic                   w_in_acc;
    logic                   w_cfg_wr;
    logic                   w_out_load;
    logic signed [2*DIFF_W-1:0] w_dsq_s;
    logic [SQ_W-1:0]        w_dsq;
    logic [SUM_W-1:0]       w_dext;
    logic [SUM_W-1:0]       w_sm;
    logic [2*CNT_W-1:0]     w_nn1;
    logic [UW-1:0]          w_qsat;
    logic [OUT_W-1:0]       w_qm;
    logic [OUT_W-1:0]       w_root;
    t_status                w_route_stat;
    logic                   w_route_go;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == 1'b0) ? {{(32-SAMPLE_BITS){r_base[SAMPLE_BITS-1]}}, r_base}
                                         : 32'd0;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // arithmetic helpers
    assign w_dsq_s = $signed(r_d) * $signed(r_d);
    assign w_dsq   = SQ_W'(w_dsq_s[2*DIFF_W-2:0]);
    assign w_dext  = {{(SUM_W-DIFF_W){r_d[DIFF_W-1]}}, r_d};
    assign w_sm    = r_sum[SUM_W-1] ? (SUM_W'(0) - r_sum) : r_sum;
    assign w_nn1   = r_cnt * (r_cnt - CNT_W'(1));
    assign w_qsat  = w_res.value;
    assign w_qm    = (w_qsat > UW'(MEAN_SAT)) ? MEAN_SAT : w_qsat[OUT_W-1:0];
    assign w_root  = (w_qsat > UW'(ROOT_SAT)) ? ROOT_SAT : w_qsat[OUT_W-1:0];

    // where to go once the mean is known
    always_comb begin
        w_route_go = 1'b0;
        if (r_ign) begin
            w_route_stat = STAT_IGNORED;
        end else if (r_cnt < CNT_W'(2)) begin
            w_route_stat = STAT_FEW;
        end else if (r_sq[SQ_W-1]) begin
            w_route_stat = STAT_NEGVAR;
        end else begin
            w_route_stat = STAT_OK;
            w_route_go   = 1'b1;
        end
    end

    // command to the shared unit for the current step
    always_comb begin
        w_cmd.start = r_launch && (r_state != S_IDLE) && (r_state != S_UPD)
                      && (r_state != S_OUT) && !((r_state == S_MEAN) && (r_cnt == '0));
        w_cmd.op    = OP_DIV;
        w_cmd.a     = r_q;
        w_cmd.b     = MB'(r_cnt);
        unique case (r_state)
            S_MEAN: w_cmd.a = UW'({w_sm, {FRAC_BITS{1'b0}}});
            S_NS2: begin
                w_cmd.op = OP_MUL;
                w_cmd.a  = UW'(r_sq);
            end
            S_SS: begin
                w_cmd.op = OP_MUL;
                w_cmd.a  = UW'(w_sm);
                w_cmd.b  = w_sm;
            end
            S_QDIV: w_cmd.b = MB'(w_nn1);
            S_SD, S_SE: w_cmd.op = OP_SQRT;
            default: ;
        endcase
    end

    rms_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_res   (w_res)
    );

    assign w_out_load = (r_state == S_OUT) && (!r_ov || !i_out_stall);

    always_comb begin
        n_state  = r_state;
        n_launch = r_launch;
        n_ign    = r_ign;
        n_cnt    = r_cnt;
        n_sum    = r_sum;
        n_sq     = r_sq;
        n_last   = r_last;
        n_status = r_status;
        n_mean   = r_mean;
        n_sd     = r_sd;
        n_se     = r_se;
        n_na     = r_na;
        n_q      = r_q;
        n_ov     = r_ov;
        if (r_ov && !i_out_stall) n_ov = 1'b0;
        if (w_cmd.start) n_launch = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_UPD;
                    n_mean  = '0;
                    n_sd    = '0;
                    n_se    = '0;
                    n_ign   = 1'b0;
                end
            end
            S_UPD: begin
                n_state  = S_MEAN;
                n_launch = 1'b1;
                unique case (r_req)
                    REQ_ADD: begin
                        if (r_cnt >= CNT_W'(COUNT_MAX)) begin
                            n_ign = 1'b1;
                        end else begin
                            n_sum  = r_sum + w_dext;
                            n_sq   = r_sq + w_dsq;
                            n_cnt  = r_cnt + CNT_W'(1);
                            n_last = r_d;
                        end
                    end
                    REQ_REMOVE: begin
                        if (r_cnt == '0) begin
                            n_ign = 1'b1;
                        end else begin
                            n_sum  = r_sum - w_dext;
                            n_sq   = r_sq - w_dsq;
                            n_cnt  = r_cnt - CNT_W'(1);
                            n_last = '0;
                        end
                    end
                    REQ_CLEAR: begin
                        n_cnt  = '0;
                        n_sum  = '0;
                        n_sq   = '0;
                        n_last = '0;
                    end
                    default: n_ign = 1'b1;
                endcase
            end
            S_MEAN: begin
                if (r_cnt == '0 || w_res.done) begin
                    if (w_res.done)
                        n_mean = r_sum[SUM_W-1] ? (OUT_W'(0) - w_qm) : w_qm;
                    n_status = w_route_stat;
                    n_launch = w_route_go;
                    n_state  = w_route_go ? S_NS2 : S_OUT;
                end
            end
            S_NS2: begin
                if (w_res.done) begin
                    n_na     = w_res.value;
                    n_state  = S_SS;
                    n_launch = 1'b1;
                end
            end
            S_SS: begin
                if (w_res.done) begin
                    if (r_na < w_res.value) begin
                        n_status = STAT_NEGVAR;
                        n_state  = S_OUT;
                    end else begin
                        n_q      = (r_na - w_res.value) << (2 * FRAC_BITS);
                        n_state  = S_QDIV;
                        n_launch = 1'b1;
                    end
                end
            end
            S_QDIV: begin
                if (w_res.done) begin
                    n_q      = w_res.value;
                    n_state  = S_SD;
                    n_launch = 1'b1;
                end
            end
            S_SD: begin
                if (w_res.done) begin
                    n_sd     = w_root;
                    n_state  = S_QN;
                    n_launch = 1'b1;
                end
            end
            S_QN: begin
                if (w_res.done) begin
                    n_q      = w_res.value;
                    n_state  = S_SE;
                    n_launch = 1'b1;
                end
            end
            S_SE: begin
                if (w_res.done) begin
                    n_se    = w_root;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
            r_ov     <= 1'b0;
            r_base   <= '0;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_sq     <= '0;
            r_last   <= '0;
            r_ign    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_ov     <= n_ov;
            r_cnt    <= n_cnt;
            r_sum    <= n_sum;
            r_sq     <= n_sq;
            r_last   <= n_last;
            r_ign    <= n_ign;
            if (w_cfg_wr && paddr[2] == 1'b0) r_base <= pwdata[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_mean   <= n_mean;
        r_sd     <= n_sd;
        r_se     <= n_se;
        r_na     <= n_na;
        r_q      <= n_q;
        if (w_in_acc) begin
            r_req <= i_req_type;
            r_d   <= DIFF_W'($signed(i_sample)) - DIFF_W'($signed(r_base));
        end
        if (w_out_load) begin
            r_o_status <= r_status;
            r_o_count  <= r_cnt;
            r_o_total  <= r_sum[32:0];
            r_o_sq     <= r_sq[48:0];
            r_o_mean   <= r_mean;
            r_o_sd     <= (r_status == STAT_OK) ? r_sd : '0;
            r_o_se     <= (r_status == STAT_OK) ? r_se : '0;
            r_o_last   <= r_last;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_o_status;
    assign o_count         = r_o_count;
    assign o_total         = r_o_total;
    assign o_total_squares = r_o_sq;
    assign o_mean_q8       = r_o_mean;
    assign o_stddev_q8     = r_o_sd;
    assign o_sem_q8        = r_o_se;
    assign o_last_value    = r_o_last;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_UPD)
        else $error("accepted item did not start an update");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(COUNT_MAX))
        else $error("sample count above limit");

    a_zero_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_status != STAT_OK) |-> (r_o_sd == '0 && r_o_se == '0))
        else $error("nonzero deviation with bad status");

    a_unit_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT || r_state == S_IDLE) |-> !w_res.busy)
        else $error("shared unit busy outside calculation");

endmodule

// ===== bench/tb.sv =====
// testbench for running_mean_stddev_sem: random and directed add/remove/clear and invalid items
// checked against a behavioral predictor of count, sums, mean, stddev and sem
// depends on rms_pkg and running_mean_stddev_sem
`timescale 1ns / 1ps

class stats_scoreboard;
    // predicted accumulator state
    logic signed [15:0] base;
    logic [15:0]        n_held;
    logic [33:0]        sum_acc;
    logic [49:0]        sq_acc;
    logic [16:0]        last_acc;
    logic [191:0]       pending[$];
    int                 errors;

    function new();
        base = 0;
        n_held = 0;
        sum_acc = 0;
        sq_acc = 0;
        last_acc = 0;
        errors = 0;
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] cc;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            cc = c * c;
            if (v >= cc) r = c;
        end
        return r;
    endfunction

    function void note_item(logic [1:0] req, logic signed [15:0] smp);
        logic signed [17:0]  d;
        logic [49:0]         dsq;
        logic                ignored;
        logic signed [33:0]  s;
        logic signed [49:0]  s2;
        logic [33:0]         sm;
        logic [63:0]         mq;
        logic [24:0]         mean, sd, se;
        logic [1:0]          st;
        logic [127:0]        a, b, q;
        logic [63:0]         r;
        d = 18'(smp) - 18'(base);
        dsq = 50'(36'(d) * 36'(d));
        ignored = 0;
        mean = 0;
        sd = 0;
        se = 0;
        case (req)
            rms_pkg::REQ_ADD: begin
                if (n_held == 16'hffff) ignored = 1;
                else begin
                    sum_acc += 34'(d);
                    sq_acc += dsq;
                    n_held++;
                    last_acc = 17'(d);
                end
            end
            rms_pkg::REQ_REMOVE: begin
                if (n_held == 0) ignored = 1;
                else begin
                    sum_acc -= 34'(d);
                    sq_acc -= dsq;
                    n_held--;
                    last_acc = 0;
                end
            end
            rms_pkg::REQ_CLEAR: begin
                n_held = 0;
                sum_acc = 0;
                sq_acc = 0;
                last_acc = 0;
            end
            default: ignored = 1;
        endcase
        s = sum_acc;
        s2 = sq_acc;
        sm = (s < 0) ? -s : s;
        if (n_held > 0) begin
            mq = (64'(sm) << 8) / n_held;
            if (mq > 64'hffffff) mq = 64'hffffff;
            mean = (s < 0) ? -25'(mq) : 25'(mq);
        end
        if (n_held < 2) st = rms_pkg::STAT_FEW;
        else if (s2 < 0) st = rms_pkg::STAT_NEGVAR;
        else begin
            a = 128'(n_held) * 128'($unsigned(s2));
            b = 128'(sm) * 128'(sm);
            if (a < b) st = rms_pkg::STAT_NEGVAR;
            else begin
                q = ((a - b) << 16) / (128'(n_held) * 128'(n_held - 1));
                r = isqrt(q);
                sd = (r > 64'h1ffffff) ? 25'h1ffffff : 25'(r);
                r = isqrt(q / n_held);
                se = (r > 64'h1ffffff) ? 25'h1ffffff : 25'(r);
                st = rms_pkg::STAT_OK;
            end
        end
        if (ignored) st = rms_pkg::STAT_IGNORED;
        if (st != rms_pkg::STAT_OK) begin
            sd = 0;
            se = 0;
        end
        pending.push_back({st, n_held, sum_acc[32:0], sq_acc[48:0], mean, sd, se, last_acc});
    endfunction

    function void check_result(logic [191:0] got);
        logic [191:0] w;
        if (pending.size() == 0) begin
            $error("result with nothing expected");
            errors++;
            return;
        end
        w = pending.pop_front();
        if (w[191:190] != got[191:190]) begin
            $error("status exp %0d got %0d", w[191:190], got[191:190]); errors++;
        end
        if (w[189:174] != got[189:174]) begin
            $error("count exp %0d got %0d", w[189:174], got[189:174]); errors++;
        end
        if (w[173:141] != got[173:141]) begin
            $error("total exp %h got %h", w[173:141], got[173:141]); errors++;
        end
        if (w[140:92] != got[140:92]) begin
            $error("total_squares exp %h got %h", w[140:92], got[140:92]); errors++;
        end
        if (w[91:67] != got[91:67]) begin
            $error("mean_q8 exp %h got %h", w[91:67], got[91:67]); errors++;
        end
        if (w[66:42] != got[66:42]) begin
            $error("stddev_q8 exp %h got %h", w[66:42], got[66:42]); errors++;
        end
        if (w[41:17] != got[41:17]) begin
            $error("sem_q8 exp %h got %h", w[41:17], got[41:17]); errors++;
        end
        if (w[16:0] != got[16:0]) begin
            $error("last_value exp %h got %h", w[16:0], got[16:0]); errors++;
        end
    endfunction
endclass

module tb;
    import rms_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_req_type;
    logic signed [15:0] i_sample;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_status;
    logic [15:0]        o_count;
    logic signed [32:0] o_total;
    logic signed [48:0] o_total_squares;
    logic signed [24:0] o_mean_q8;
    logic [24:0]        o_stddev_q8;
    logic [24:0]        o_sem_q8;
    logic signed [16:0] o_last_value;

    localparam int BASE_REG = 0;
    localparam longint LIMIT = 4000000;

    stats_scoreboard sb;
    int  send_idle_pct;
    int  stall_pct;
    longint cycles;

    running_mean_stddev_sem dut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // receiver: random stall, check on accept
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_status, o_count, o_total, o_total_squares, o_mean_q8,
                             o_stddev_q8, o_sem_q8, o_last_value});
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic write_base(logic signed [15:0] v);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= 3'(4 * BASE_REG); pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.base = v;
    endtask

    // valid stays high into the next item unless the sender idles
    task automatic send(logic [1:0] req, logic signed [15:0] smp);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1; i_req_type <= req; i_sample <= smp;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(req, smp);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(16) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [1:0] r;
        int k;
        sb = new();
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        i_in_valid = 0; i_req_type = 0; i_sample = 0; i_out_stall = 0;
        send_idle_pct = 0; stall_pct = 0;
        i_rst_n = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: ignored cases, extremes, negative sum of squares
        send(REQ_REMOVE, 16'sd5);
        send(REQ_ADD, 16'sh7fff);
        send(REQ_ADD, 16'sh8000);
        send(REQ_ADD, 16'sd3);
        send(2'd3, 16'sd1);
        send(REQ_REMOVE, 16'sh8000);
        send(REQ_REMOVE, 16'sd100);
        send(REQ_ADD, 16'sd0);
        send(REQ_REMOVE, 16'sh7fff);
        send(REQ_REMOVE, 16'sh7fff);
        send(REQ_CLEAR, 16'shffff);
        send(REQ_ADD, 16'sd7);
        send(REQ_ADD, 16'sd7);
        send(REQ_ADD, -16'sd9);
        send(REQ_CLEAR, 16'sd0);
        drain();
        write_base(16'sh8000);
        send(REQ_ADD, 16'sh7fff);
        send(REQ_ADD, 16'sh7fff);
        send(REQ_ADD, 16'sh8000);
        drain();
        write_base(16'sh7fff);
        send(REQ_ADD, 16'sh8000);
        send(REQ_ADD, 16'sh8000);
        send(REQ_ADD, 16'sh7ffe);
        send(REQ_CLEAR, 16'sd0);
        drain();

        // random phases, each with an idling setting picked by phase mod 4 and its own base value
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 81; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 21; stall_pct = 21; end
            endcase
            write_base(ph == 5 ? 16'sd0 : 16'($urandom));
            for (k = 0; k < 220; k++) begin
                r = $urandom_range(99) < 70 ? REQ_ADD :
                    $urandom_range(99) < 85 ? REQ_REMOVE :
                    $urandom_range(1) ? REQ_CLEAR : 2'd3;
                send(r, rand_sample());
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
